@@ design/cmfr_pkg.sv @@
// Package for the cell monitor frame receiver: transaction types, frame constants,
// configuration register indexes and the CRC-8 byte update.
// No dependencies.
package cmfr_pkg;

    localparam int CELLS_DEF = 6;

    localparam logic [7:0] START_BYTE = 8'h3E;
    localparam logic [7:0] END_BYTE   = 8'hEE;
    localparam logic [7:0] CRC_POLY   = 8'h8C;
    localparam logic [7:0] UNSET      = 8'hFF;

    localparam int ADC_W  = 16;
    localparam int SCL_W  = 10;
    localparam int PROD_W = ADC_W + SCL_W;

    // cell record: voltage, pwm, peak voltage, low voltage, peak pwm
    localparam int REC_W = 40;

    typedef enum logic [2:0] {
        CFG_TIMEOUT  = 3'd0,
        CFG_GIVE_UP  = 3'd1,
        CFG_BAUD_LO  = 3'd2,
        CFG_BAUD_HI  = 3'd3,
        CFG_BAUD_STP = 3'd4,
        CFG_SCALE    = 3'd5,
        CFG_OFFSET   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  event_cell;
        logic [7:0]  cell_voltage;
        logic [7:0]  cell_pwm;
        logic        frame_ok;
        logic        cell_gave_up;
        logic        store_max_voltage;
        logic        store_min_voltage;
        logic        store_max_pwm;
        logic [7:0]  status_main;
        logic [1:0]  status_full;
        logic [15:0] baud_reload;
        logic [2:0]  active_cell;
    } t_out_item;

    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ design/cmfr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cmfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ design/cmfr_div.sv @@
// Restoring divider, one quotient bit per cycle, for the voltage ratio.
// Depends on cmfr_pkg.
module cmfr_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [cmfr_pkg::PROD_W-1:0]    i_dividend,
    input  logic [cmfr_pkg::ADC_W-1:0]     i_divisor,
    output logic                           o_done,
    output logic [cmfr_pkg::PROD_W-1:0]    o_quotient
);
    import cmfr_pkg::*;

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [ADC_W:0]    r_rem;
    logic [PROD_W-1:0] r_q;
    logic [ADC_W-1:0]  r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [ADC_W:0]    rem_sh;
    logic              fits;

    assign rem_sh = {r_rem[ADC_W-1:0], r_q[PROD_W-1]};
    assign fits   = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= fits ? rem_sh - {1'b0, r_div} : rem_sh;
                r_q   <= {r_q[PROD_W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(PROD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

@@ design/cell_monitor_frame_receiver.sv @@
// Cell monitor frame receiver: serial bytes and timer ticks in, one result per transaction out.
// A byte or a tick without an event goes from S_EXEC to S_DONE. A frame with a good CRC passes
// the one-bit-per-cycle divider (26 steps, skipped for a zero reference) and the record memory
// read-modify-write; a give-up only the latter. When the poll wraps past the last cell, a summary
// sweep over the record memory follows. The next transaction is taken once the current one has
// its result in the output register. Depends on cmfr_pkg, cmfr_ram and cmfr_div.
module cell_monitor_frame_receiver #(
    parameter int CELLS = cmfr_pkg::CELLS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  cmfr_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output cmfr_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);
    import cmfr_pkg::*;

    localparam int CW = $clog2(CELLS);
    localparam int KW = $clog2(CELLS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_MUL, S_DIVS, S_DIV, S_RMW, S_SUM, S_DONE
    } t_state;

    t_state r_state;

    logic [3:0]  r_cfg_tmo;
    logic [7:0]  r_cfg_give;
    logic [15:0] r_cfg_lo, r_cfg_hi;
    logic [7:0]  r_cfg_step;
    logic [9:0]  r_cfg_scale, r_cfg_off;

    t_in_item    r_item;
    t_out_item   r_res;
    t_out_item   r_out;
    logic        r_ovalid;
    logic        r_gave;

    logic [3:0]  r_bcnt;
    logic [7:0]  r_crc, r_rxcrc, r_pwm;
    logic [15:0] r_adc, r_ref;
    logic [CW-1:0] r_cell;
    logic [3:0]  r_tick;
    logic [7:0]  r_tmo;
    logic [15:0] r_sweep;
    logic [7:0]  r_main;
    logic [1:0]  r_full;
    logic [7:0]  r_v;
    logic [PROD_W-1:0] r_prod;
    logic [CELLS-1:0]  r_valid;
    logic        r_rd_valid;
    logic [KW-1:0] r_k, r_cnt_full, r_cnt_ok;

    logic [CW-1:0]     rd_addr;
    logic [REC_W-1:0]  ram_q, rec, wr_data;
    logic              ram_we;
    logic              div_done;
    logic [PROD_W-1:0] div_q;

    logic [3:0]  tick_inc;
    logic        tmo_hit;
    logic [7:0]  tmo_inc;
    logic [16:0] sum17;
    logic [15:0] swp;
    logic [7:0]  o_v, o_p, o_pk, o_lo, o_pp;
    logic        smax, smin, spwm;
    logic [7:0]  pk_n, lo_n, pp_n;
    logic [7:0]  cell_bit, main_n;
    logic        wrap;
    logic [KW-1:0] full_n, ok_n;
    logic [PROD_W-1:0] q_off;
    t_out_item   out_n;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    assign rd_addr = (r_state == S_SUM) ? ((r_k < KW'(CELLS)) ? r_k[CW-1:0] : '0) : r_cell;
    assign ram_we  = (r_state == S_RMW);

    cmfr_ram #(.WIDTH(REC_W), .DEPTH(CELLS)) u_rec (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cell),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    cmfr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIVS),
        .i_dividend (r_prod),
        .i_divisor  (r_ref),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        rec = r_rd_valid ? ram_q : '1;
        {o_v, o_p, o_pk, o_lo, o_pp} = rec;
        tick_inc = (r_tick < 4'd15) ? r_tick + 4'd1 : r_tick;
        tmo_hit  = tick_inc >= r_cfg_tmo;
        tmo_inc  = (r_tmo == 8'd255) ? r_tmo : r_tmo + 8'd1;
        sum17    = {1'b0, r_sweep} + {9'd0, r_cfg_step};
        swp      = (sum17 >= {1'b0, r_cfg_hi} || sum17 <= {1'b0, r_cfg_lo})
                   ? r_cfg_lo : sum17[15:0];
        smax = (r_v > o_pk) || (o_pk == UNSET);
        smin = (r_v < o_lo) || (o_lo == UNSET);
        spwm = (r_pwm > o_pp) || (o_pp == UNSET);
        pk_n = smax ? r_v : o_pk;
        lo_n = smin ? r_v : o_lo;
        pp_n = spwm ? r_pwm : o_pp;
        wr_data = r_gave ? {UNSET, UNSET, o_pk, o_lo, o_pp}
                         : {r_v, r_pwm, pk_n, lo_n, pp_n};
        cell_bit = 8'd1 << r_cell;
        wrap     = (r_cell == CW'(CELLS - 1));
        main_n   = r_gave ? (r_main & ~cell_bit) : (r_main | cell_bit);
        if (wrap) begin
            main_n[7] = 1'b1;
        end
        full_n = r_cnt_full;
        ok_n   = r_cnt_ok;
        if (r_k != '0) begin
            if (o_p != 8'd0 && o_p != UNSET) begin
                full_n = r_cnt_full + 1'b1;
            end
            if (o_v != UNSET) begin
                ok_n = r_cnt_ok + 1'b1;
            end
        end
        q_off = div_q - PROD_W'(r_cfg_off);
        out_n             = r_res;
        out_n.status_main = r_main;
        out_n.status_full = r_full;
        out_n.baud_reload = r_sweep;
        out_n.active_cell = 3'(r_cell);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cfg_tmo  <= 4'd2;
            r_cfg_give <= 8'd35;
            r_cfg_lo   <= 16'd64935;
            r_cfg_hi   <= 16'd65100;
            r_cfg_step <= 8'd5;
            r_cfg_scale <= 10'd420;
            r_cfg_off  <= 10'd200;
            r_ovalid   <= 1'b0;
            r_gave     <= 1'b0;
            r_bcnt     <= '0;
            r_cell     <= '0;
            r_tick     <= '0;
            r_tmo      <= '0;
            r_sweep    <= 16'd64955;
            r_main     <= '0;
            r_full     <= '0;
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_k        <= '0;
            r_cnt_full <= '0;
            r_cnt_ok   <= '0;
        end else begin
            r_rd_valid <= r_valid[rd_addr];
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_TIMEOUT:  r_cfg_tmo   <= i_cfg_data[3:0];
                    CFG_GIVE_UP:  r_cfg_give  <= i_cfg_data[7:0];
                    CFG_BAUD_LO:  r_cfg_lo    <= i_cfg_data;
                    CFG_BAUD_HI:  r_cfg_hi    <= i_cfg_data;
                    CFG_BAUD_STP: r_cfg_step  <= i_cfg_data[7:0];
                    CFG_SCALE:    r_cfg_scale <= i_cfg_data[9:0];
                    CFG_OFFSET:   r_cfg_off   <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (r_state == S_DONE && (!r_ovalid || !i_out_stall)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_data;
                        r_gave  <= 1'b0;
                        r_res   <= '0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (!r_item.cmd) begin
                        if (r_item.rx_byte == START_BYTE) begin
                            r_bcnt  <= 4'd1;
                            r_crc   <= crc_byte(8'd0, START_BYTE);
                            r_state <= S_DONE;
                        end else if (r_bcnt != '0) begin
                            if (r_bcnt >= 4'd7) begin
                                r_bcnt <= '0;
                                if (r_item.rx_byte == END_BYTE && r_crc == r_rxcrc) begin
                                    r_state <= S_MUL;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end else begin
                                unique case (r_bcnt)
                                    4'd1: r_adc[15:8] <= r_item.rx_byte;
                                    4'd2: r_adc[7:0]  <= r_item.rx_byte;
                                    4'd3: r_ref[15:8] <= r_item.rx_byte;
                                    4'd4: r_ref[7:0]  <= r_item.rx_byte;
                                    4'd5: r_pwm       <= r_item.rx_byte;
                                    default: r_rxcrc  <= r_item.rx_byte;
                                endcase
                                if (r_bcnt <= 4'd5) begin
                                    r_crc <= crc_byte(r_crc, r_item.rx_byte);
                                end
                                r_bcnt  <= r_bcnt + 4'd1;
                                r_state <= S_DONE;
                            end
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_tick <= tmo_hit ? 4'd0 : tick_inc;
                        if (tmo_hit) begin
                            r_tmo   <= tmo_inc;
                            r_sweep <= swp;
                        end
                        if (tmo_hit && tmo_inc >= r_cfg_give) begin
                            r_gave  <= 1'b1;
                            r_state <= S_RMW;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_MUL: begin
                    r_prod <= PROD_W'(r_adc) * PROD_W'(r_cfg_scale);
                    if (r_ref == '0) begin
                        r_v     <= UNSET;
                        r_state <= S_RMW;
                    end else begin
                        r_state <= S_DIVS;
                    end
                end
                S_DIVS: r_state <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        if (div_q <= PROD_W'(r_cfg_off)) begin
                            r_v <= 8'd0;
                        end else if (q_off > PROD_W'(255)) begin
                            r_v <= UNSET;
                        end else begin
                            r_v <= q_off[7:0];
                        end
                        r_state <= S_RMW;
                    end
                end
                S_RMW: begin
                    r_valid[r_cell]      <= 1'b1;
                    r_res.event_cell     <= 3'(r_cell);
                    r_res.frame_ok       <= !r_gave;
                    r_res.cell_gave_up   <= r_gave;
                    r_res.cell_voltage   <= r_gave ? UNSET : r_v;
                    r_res.cell_pwm       <= r_gave ? UNSET : r_pwm;
                    r_res.store_max_voltage <= !r_gave && smax;
                    r_res.store_min_voltage <= !r_gave && smin;
                    r_res.store_max_pwm  <= !r_gave && spwm;
                    r_main <= main_n;
                    r_tick <= '0;
                    r_tmo  <= '0;
                    r_bcnt <= '0;
                    if (wrap) begin
                        r_cell     <= '0;
                        r_k        <= '0;
                        r_cnt_full <= '0;
                        r_cnt_ok   <= '0;
                        r_state    <= S_SUM;
                    end else begin
                        r_cell  <= r_cell + 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_SUM: begin
                    r_cnt_full <= full_n;
                    r_cnt_ok   <= ok_n;
                    r_k        <= r_k + 1'b1;
                    if (r_k == KW'(CELLS)) begin
                        r_full    <= {full_n != '0, full_n == KW'(CELLS)};
                        r_main[6] <= (ok_n == KW'(CELLS));
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_out   <= out_n;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ sim/tb_top.sv @@
// Testbench for cell_monitor_frame_receiver: random and directed byte/tick transactions,
// a built-in predictor of the frame receiver, and a whole-result comparison check.
// Depends on cmfr_pkg and the cell_monitor_frame_receiver RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cmfr_pkg::*;

    localparam int NCELL = 6;
    localparam int WDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_item o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    cell_monitor_frame_receiver #(.CELLS(NCELL)) dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [3:0]  r_tmo_ticks;
    logic [7:0]  r_give_up;
    logic [15:0] r_baud_lo, r_baud_hi;
    logic [7:0]  r_baud_step;
    logic [9:0]  r_scale, r_offset;
    logic [7:0]  fr_bytes[7];
    int          fr_count, cur_cell, tick_cnt, tmo_cnt;
    logic [15:0] sweep;
    logic [7:0]  volt_st[NCELL], pwm_st[NCELL], pk_volt[NCELL], lo_volt[NCELL], pk_pwm[NCELL];
    logic [7:0]  main_fl;
    logic [1:0]  full_fl;

    t_in_item  byte_queue[$];
    t_out_item expected_results[$];
    int  errors = 0;
    bit  calm = 1'b0;
    int  src_gap = 0, sink_gap = 0, idle_cycles = 0;

    function automatic logic [7:0] crc_next(logic [7:0] c, logic [7:0] d);
        c = c ^ d;
        for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
        return c;
    endfunction

    function automatic logic [7:0] frame_crc(logic [7:0] b[6]);
        logic [7:0] c;
        c = 8'h00;
        for (int i = 0; i < 6; i++) c = crc_next(c, b[i]);
        return c;
    endfunction

    task automatic advance_cell();
        int nfull, nok;
        nfull = 0;
        nok = 0;
        tick_cnt = 0;
        tmo_cnt = 0;
        fr_count = 0;
        cur_cell++;
        if (cur_cell >= NCELL) begin
            cur_cell = 0;
            main_fl[7] = 1'b1;
            full_fl = 2'b00;
            for (int i = 0; i < NCELL; i++) begin
                if (pwm_st[i] != 8'h00 && pwm_st[i] != UNSET) begin
                    nfull++;
                    full_fl[1] = 1'b1;
                end
                if (volt_st[i] != UNSET) nok++;
            end
            if (nfull == NCELL) full_fl[0] = 1'b1;
            main_fl[6] = (nok == NCELL);
        end
    endtask

    function automatic logic [7:0] volt_code();
        longint adc, vref, q;
        adc = {fr_bytes[1], fr_bytes[2]};
        vref = {fr_bytes[3], fr_bytes[4]};
        if (vref == 0) return 8'hFF;
        q = (adc * r_scale) / vref;
        if (q <= r_offset) return 8'h00;
        q -= r_offset;
        return (q > 255) ? 8'hFF : q[7:0];
    endfunction

    task automatic predict_receiver(t_in_item it);
        t_out_item r;
        int c, s;
        logic [7:0] v, p;
        logic [7:0] crc;
        r = '0;
        c = cur_cell;
        if (it.cmd == 1'b0) begin
            if (it.rx_byte == START_BYTE) begin
                fr_bytes[0] = it.rx_byte;
                fr_count = 1;
            end else if (fr_count > 0) begin
                if (fr_count >= 7) begin
                    fr_count = 0;
                    crc = 8'h00;
                    for (int i = 0; i < 6; i++) crc = crc_next(crc, fr_bytes[i]);
                    if (it.rx_byte == END_BYTE && crc == fr_bytes[6]) begin
                        v = volt_code();
                        p = fr_bytes[5];
                        volt_st[c] = v;
                        pwm_st[c] = p;
                        main_fl[c] = 1'b1;
                        if (v > pk_volt[c] || pk_volt[c] == UNSET) begin
                            pk_volt[c] = v;
                            r.store_max_voltage = 1'b1;
                        end
                        if (v < lo_volt[c] || lo_volt[c] == UNSET) begin
                            lo_volt[c] = v;
                            r.store_min_voltage = 1'b1;
                        end
                        if (p > pk_pwm[c] || pk_pwm[c] == UNSET) begin
                            pk_pwm[c] = p;
                            r.store_max_pwm = 1'b1;
                        end
                        r.frame_ok = 1'b1;
                        r.event_cell = c;
                        r.cell_voltage = v;
                        r.cell_pwm = p;
                        advance_cell();
                    end
                end else begin
                    fr_bytes[fr_count] = it.rx_byte;
                    fr_count++;
                end
            end
        end else begin
            if (tick_cnt < 15) tick_cnt++;
            if (tick_cnt >= r_tmo_ticks) begin
                tick_cnt = 0;
                if (tmo_cnt < 255) tmo_cnt++;
                s = sweep + r_baud_step;
                if (s >= r_baud_hi) s = r_baud_lo;
                if (s <= r_baud_lo) s = r_baud_lo;
                sweep = s[15:0];
                if (tmo_cnt >= r_give_up) begin
                    volt_st[c] = UNSET;
                    pwm_st[c] = UNSET;
                    main_fl[c] = 1'b0;
                    r.cell_gave_up = 1'b1;
                    r.event_cell = c;
                    r.cell_voltage = UNSET;
                    r.cell_pwm = UNSET;
                    advance_cell();
                end
            end
        end
        r.status_main = main_fl;
        r.status_full = full_fl;
        r.baud_reload = sweep;
        r.active_cell = cur_cell;
        expected_results.push_back(r);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || !o_in_stall) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (byte_queue.size() > 0) begin
                    i_in_data <= byte_queue.pop_front();
                    i_in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 18);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                i_out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                sink_gap <= $urandom_range(1, 18) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) predict_receiver(i_in_data);
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %p", $realtime, o_out_data);
                end else begin
                    t_out_item e;
                    e = expected_results.pop_front();
                    if (e !== o_out_data) begin
                        errors++;
                        $display("%0t: expected %p", $realtime, e);
                        $display("%0t: actual   %p", $realtime, o_out_data);
                    end
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WDOG_LIMIT) begin
                $display("cell_monitor_frame_receiver: mismatch");
                $finish;
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_TIMEOUT:  r_tmo_ticks = val[3:0];
            CFG_GIVE_UP:  r_give_up = val[7:0];
            CFG_BAUD_LO:  r_baud_lo = val;
            CFG_BAUD_HI:  r_baud_hi = val;
            CFG_BAUD_STP: r_baud_step = val[7:0];
            CFG_SCALE:    r_scale = val[9:0];
            default:      r_offset = val[9:0];
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (byte_queue.size() > 0 || expected_results.size() > 0 || i_in_valid)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic push_byte(logic [7:0] b);
        t_in_item it;
        it.cmd = 1'b0;
        it.rx_byte = b;
        byte_queue.push_back(it);
    endtask

    task automatic push_tick();
        t_in_item it;
        it.cmd = 1'b1;
        it.rx_byte = $urandom_range(0, 255);
        byte_queue.push_back(it);
    endtask

    // flaw: 0 good, 1 bad crc, 2 bad end byte, 3 restart mid frame, 4 truncated
    task automatic push_frame(logic [15:0] adc, logic [15:0] vref, logic [7:0] pwm, int flaw);
        logic [7:0] b[6];
        logic [7:0] crc, tail;
        b = '{START_BYTE, adc[15:8], adc[7:0], vref[15:8], vref[7:0], pwm};
        crc = frame_crc(b);
        if (flaw == 1) crc ^= 8'h01 << $urandom_range(0, 7);
        tail = END_BYTE;
        if (flaw == 2) begin
            tail = $urandom_range(0, 255);
            if (tail == END_BYTE) tail = 8'h00;
        end
        for (int i = 0; i < 6; i++) begin
            if (flaw == 3 && i == 3) push_byte(START_BYTE);
            if (flaw == 4 && i == 4) return;
            push_byte(b[i]);
        end
        push_byte(crc);
        push_byte(tail);
    endtask

    task automatic random_traffic(int n);
        int k, sel;
        k = 0;
        while (k < n) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                push_frame($urandom_range(0, 65535),
                           ($urandom_range(0, 19) == 0) ? 16'h0 : $urandom_range(0, 65535),
                           $urandom_range(0, 255),
                           ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0);
                k += 8;
            end else if (sel < 88) begin
                push_tick();
                k++;
            end else begin
                push_byte($urandom_range(0, 255));
                k++;
            end
        end
    endtask

    initial begin
        r_tmo_ticks = 4'd2;
        r_give_up = 8'd35;
        r_baud_lo = 16'd64935;
        r_baud_hi = 16'd65100;
        r_baud_step = 8'd5;
        r_scale = 10'd420;
        r_offset = 10'd200;
        fr_count = 0;
        cur_cell = 0;
        tick_cnt = 0;
        tmo_cnt = 0;
        sweep = 16'd64955;
        foreach (volt_st[i]) begin
            volt_st[i] = UNSET;
            pwm_st[i] = UNSET;
            pk_volt[i] = UNSET;
            lo_volt[i] = UNSET;
            pk_pwm[i] = UNSET;
        end
        main_fl = '0;
        full_fl = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, zero ref, clamps, each broken frame kind, timeouts
        push_byte(8'h55);
        push_frame(16'hFFFF, 16'h0001, 8'hFF, 0);
        push_frame(16'h0000, 16'hFFFF, 8'h00, 0);
        push_frame(16'h1234, 16'h0000, 8'h80, 0);
        push_frame(16'h0800, 16'h0400, 8'h01, 1);
        push_frame(16'h0800, 16'h0400, 8'h01, 2);
        push_frame(16'h0800, 16'h0400, 8'h01, 3);
        push_frame(16'h0800, 16'h0400, 8'h01, 4);
        repeat (80) push_tick();
        wait_drained();

        write_reg(CFG_TIMEOUT, 16'd1);
        write_reg(CFG_GIVE_UP, 16'd3);
        write_reg(CFG_BAUD_LO, 16'd0);
        write_reg(CFG_BAUD_HI, 16'hFFFF);
        write_reg(CFG_BAUD_STP, 16'd255);
        write_reg(CFG_SCALE, 16'd1023);
        write_reg(CFG_OFFSET, 16'd0);
        random_traffic(140);
        wait_drained();

        write_reg(CFG_TIMEOUT, 16'd15);
        write_reg(CFG_GIVE_UP, 16'd255);
        write_reg(CFG_BAUD_LO, 16'hFFFF);
        write_reg(CFG_BAUD_HI, 16'd0);
        write_reg(CFG_BAUD_STP, 16'd0);
        write_reg(CFG_SCALE, 16'd0);
        write_reg(CFG_OFFSET, 16'd1023);
        random_traffic(100);
        wait_drained();

        write_reg(CFG_TIMEOUT, $urandom_range(1, 4));
        write_reg(CFG_GIVE_UP, $urandom_range(1, 6));
        write_reg(CFG_BAUD_LO, $urandom_range(0, 65535));
        write_reg(CFG_BAUD_HI, $urandom_range(0, 65535));
        write_reg(CFG_BAUD_STP, $urandom_range(0, 255));
        write_reg(CFG_SCALE, $urandom_range(0, 1023));
        write_reg(CFG_OFFSET, $urandom_range(0, 1023));
        random_traffic(200);
        while (byte_queue.size() > 80) @(posedge i_clk);
        calm = 1'b1;
        random_traffic(100);
        wait_drained();

        if (errors == 0)
            $display("cell_monitor_frame_receiver: match");
        else
            $display("cell_monitor_frame_receiver: mismatch");
        $finish;
    end
endmodule

@@ files.f @@
design/cmfr_pkg.sv
design/cmfr_ram.sv
design/cmfr_div.sv
design/cell_monitor_frame_receiver.sv
sim/tb_top.sv
